### hw/rtl/fbm_wear_pkg.sv
// ----------------------------------------------------------------------------
// fbm_wear_pkg: shared types and constants of the flash block map
// Item layouts, block states, result codes, operation codes and FSM states.
// ----------------------------------------------------------------------------
package fbm_wear_pkg;

	localparam int NUM_BLOCKS_DEF = 1024;
	localparam int ERASE_BITS_DEF = 32;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_RESERVED = 1'b1;

	// operation codes
	localparam logic [3:0] FN_LOOKUP = 4'd0;
	localparam logic [3:0] FN_SET    = 4'd1;
	localparam logic [3:0] FN_ALLOC  = 4'd2;
	localparam logic [3:0] FN_FREE   = 4'd3;
	localparam logic [3:0] FN_DIRTY  = 4'd4;
	localparam logic [3:0] FN_BAD    = 4'd5;
	localparam logic [3:0] FN_INFO   = 4'd6;
	localparam logic [3:0] FN_ERASE  = 4'd7;
	localparam logic [3:0] FN_MIN    = 4'd8;
	localparam logic [3:0] FN_MAX    = 4'd9;
	localparam logic [3:0] FN_REINIT = 4'd10;

	typedef enum logic [1:0] {
		BS_FREE   = 2'd0,
		BS_ACTIVE = 2'd1,
		BS_DIRTY  = 2'd2,
		BS_BAD    = 2'd3
	} blk_state_t;

	typedef enum logic [1:0] {
		RC_OK      = 2'd0,
		RC_INVALID = 2'd1,
		RC_NOFREE  = 2'd2,
		RC_NONE    = 2'd3
	} rc_t;

	typedef enum logic [3:0] {
		S_SWEEP,
		S_IDLE,
		S_LOOK,
		S_SET1,
		S_SET2,
		S_SET3,
		S_REL1,
		S_REL2,
		S_PMOD,
		S_SCAN,
		S_SCANEND,
		S_SCANFIN,
		S_DONE
	} fsm_t;

	typedef struct packed {
		logic [3:0] func;
		logic [9:0] lblk;
		logic [9:0] pblk;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [10:0] found_physical;
		logic [10:0] owner_logical;
		logic [1:0]  block_state;
		logic [31:0] wear_cnt;
		logic [10:0] free_cnt;
		logic [10:0] dirty_cnt;
		logic [10:0] bad_cnt;
	} out_item_t;

endpackage

### hw/rtl/flash_block_map_wear_allocator.sv
// ----------------------------------------------------------------------------
// flash_block_map_wear_allocator: flash block map with wear-aware allocation
// Logical-to-physical map plus per-block owner, state and erase count.
// ----------------------------------------------------------------------------
// One operation per input item, one result item per operation, unless a
// configuration write cuts the operation short. Set mapping passes an extra
// state when the logical block was already mapped, and free/bad one when the
// block had an owner. Allocate, find-min and find-max walk every block in use
// through the single read port of the block memory. Reinitialize rewrites
// both memories one entry per cycle. After reset and after every
// configuration write the same clearing pass over all NUM_BLOCKS entries
// runs and no item is taken until it ends. A finished result sits in an
// output register, so the next item is accepted while the previous result
// still waits.
// ----------------------------------------------------------------------------
module flash_block_map_wear_allocator
	import fbm_wear_pkg::*;
#(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
	parameter int ERASE_BITS = ERASE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  in_item_t              in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output out_item_t             out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IW    = $clog2(NUM_BLOCKS);
	localparam int LW    = $clog2(NUM_BLOCKS + 1);
	localparam int CMP_W = (LW > 11) ? LW : 11;
	localparam int EW    = ERASE_BITS;

	localparam logic [LW-1:0] NONE_IDX  = LW'(NUM_BLOCKS);
	localparam logic [IW-1:0] LAST_IDX  = IW'(NUM_BLOCKS - 1);
	localparam logic [EW-1:0] ERASE_MAX = '1;

	typedef struct packed {
		logic [LW-1:0] owner;
		blk_state_t    st;
		logic [EW-1:0] wear;
	} pent_t;

	typedef struct packed {
		rc_t           rc;
		logic [LW-1:0] found;
		logic [LW-1:0] owner;
		blk_state_t    bst;
		logic [EW-1:0] ec;
	} res_t;

	// memories: logical map and per-block info
	logic [LW-1:0] lmem [NUM_BLOCKS];
	pent_t         pmem [NUM_BLOCKS];

	logic [IW-1:0] l_ra, l_wa, p_ra, p_wa;
	logic          l_we, p_we;
	logic [LW-1:0] l_wd, l_rd;
	pent_t         p_wd, p_rd;

	// configuration
	logic [10:0] total_q;
	logic [9:0]  reserved_q;
	logic [CMP_W-1:0] eff_total, eff_logical, tot_ext, res_ext;

	// control and datapath
	fsm_t          state_q, state_d;
	logic [3:0]    func_q, func_d;
	logic [9:0]    lb_q, lb_d, pb_q, pb_d;
	logic [LW-1:0] aux_q, aux_d;
	logic [IW-1:0] cnt_q, cnt_d;
	logic          sweep_res_q, sweep_res_d;
	logic          scan_vld_s1;
	logic [IW-1:0] scan_idx_s1;
	logic          scan_start;
	logic [LW-1:0] best_q;
	logic [EW-1:0] bestc_q;
	pent_t         bent_q;
	logic          scan_hit;
	res_t          res_q, res_d;
	logic          out_free;
	logic          out_load;
	out_item_t     out_q;
	logic          out_valid_q;

	// running totals
	logic [LW-1:0] free_q, dirty_q, bad_q;
	logic [LW-1:0] free_d, dirty_d, bad_d;
	logic          cnt_en;
	blk_state_t    cnt_old, cnt_new;
	logic          sweep_end;
	logic          lok, pok;

	always_comb begin
		tot_ext = CMP_W'(total_q);
		res_ext = CMP_W'(reserved_q);
		if (tot_ext == '0) begin
			eff_total = CMP_W'(1);
		end else if (tot_ext > CMP_W'(NUM_BLOCKS)) begin
			eff_total = CMP_W'(NUM_BLOCKS);
		end else begin
			eff_total = tot_ext;
		end
		eff_logical = (res_ext < eff_total) ? (eff_total - res_ext) : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= 11'd1024;
			reserved_q <= 10'd32;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOTAL:    total_q    <= cfg_data;
				REG_RESERVED: reserved_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	// memory ports: one write and one registered read each
	always_ff @(posedge clk) begin
		if (l_we) begin
			lmem[l_wa] <= l_wd;
		end
		l_rd <= lmem[l_ra];
	end

	always_ff @(posedge clk) begin
		if (p_we) begin
			pmem[p_wa] <= p_wd;
		end
		p_rd <= pmem[p_ra];
	end

	assign lok      = CMP_W'(in_item.lblk) < eff_logical;
	assign pok      = CMP_W'(in_item.pblk) < eff_total;
	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == S_IDLE);

	// next state, memory ports and result fields
	always_comb begin
		state_d     = state_q;
		func_d      = func_q;
		lb_d        = lb_q;
		pb_d        = pb_q;
		aux_d       = aux_q;
		cnt_d       = cnt_q;
		sweep_res_d = sweep_res_q;
		res_d       = res_q;
		scan_start  = 1'b0;
		sweep_end   = 1'b0;
		out_load    = 1'b0;
		cnt_en      = 1'b0;
		cnt_old     = BS_ACTIVE;
		cnt_new     = BS_ACTIVE;
		l_ra        = IW'(in_item.lblk);
		p_ra        = IW'(in_item.pblk);
		l_we        = 1'b0;
		l_wa        = IW'(lb_q);
		l_wd        = LW'(pb_q);
		p_we        = 1'b0;
		p_wa        = IW'(pb_q);
		p_wd        = p_rd;

		unique case (state_q)
			S_SWEEP: begin
				l_we = 1'b1;
				l_wa = cnt_q;
				p_we = 1'b1;
				p_wa = cnt_q;
				if (CMP_W'(cnt_q) < eff_logical) begin
					l_wd = LW'(cnt_q);
					p_wd = '{owner: LW'(cnt_q), st: BS_ACTIVE, wear: '0};
				end else begin
					l_wd = NONE_IDX;
					p_wd = '{owner: NONE_IDX, st: BS_FREE, wear: '0};
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == LAST_IDX) begin
					sweep_end = 1'b1;
					state_d   = sweep_res_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					func_d = in_item.func;
					lb_d   = in_item.lblk;
					pb_d   = in_item.pblk;
					res_d  = '{rc: RC_OK, found: '0, owner: '0, bst: BS_FREE, ec: '0};
					cnt_d  = '0;
					unique case (in_item.func)
						FN_LOOKUP: begin
							state_d = lok ? S_LOOK : S_DONE;
						end
						FN_SET: begin
							state_d = (lok && pok) ? S_SET1 : S_DONE;
						end
						FN_FREE, FN_BAD: begin
							state_d = pok ? S_REL1 : S_DONE;
						end
						FN_DIRTY, FN_INFO, FN_ERASE: begin
							state_d = pok ? S_PMOD : S_DONE;
						end
						FN_ALLOC, FN_MIN, FN_MAX: begin
							scan_start = 1'b1;
							state_d    = S_SCAN;
						end
						FN_REINIT: begin
							sweep_res_d = 1'b1;
							state_d     = S_SWEEP;
						end
						default: state_d = S_DONE;
					endcase
					if (state_d == S_DONE) begin
						res_d.rc = RC_INVALID;
					end
				end
			end
			S_LOOK: begin
				res_d.found = l_rd;
				state_d     = S_DONE;
			end
			S_SET1: begin
				aux_d = l_rd;
				if (CMP_W'(l_rd) < eff_total) begin
					p_ra    = IW'(l_rd);
					state_d = S_SET2;
				end else begin
					p_ra    = IW'(pb_q);
					state_d = S_SET3;
				end
			end
			S_SET2: begin
				// old block loses its owner; a same-address read sees old data,
				// which is harmless since the owner is rewritten next
				p_we    = 1'b1;
				p_wa    = IW'(aux_q);
				p_wd    = '{owner: NONE_IDX, st: p_rd.st, wear: p_rd.wear};
				p_ra    = IW'(pb_q);
				state_d = S_SET3;
			end
			S_SET3: begin
				p_we    = 1'b1;
				p_wd    = '{owner: LW'(lb_q), st: BS_ACTIVE, wear: p_rd.wear};
				l_we    = 1'b1;
				cnt_en  = 1'b1;
				cnt_old = p_rd.st;
				cnt_new = BS_ACTIVE;
				state_d = S_DONE;
			end
			S_REL1: begin
				p_we    = 1'b1;
				cnt_en  = 1'b1;
				cnt_old = p_rd.st;
				cnt_new = (func_q == FN_FREE) ? BS_FREE : BS_BAD;
				p_wd    = '{owner: NONE_IDX, st: cnt_new, wear: p_rd.wear};
				aux_d   = p_rd.owner;
				if (CMP_W'(p_rd.owner) < eff_logical) begin
					l_ra    = IW'(p_rd.owner);
					state_d = S_REL2;
				end else begin
					state_d = S_DONE;
				end
			end
			S_REL2: begin
				if (l_rd == LW'(pb_q)) begin
					l_we = 1'b1;
					l_wa = IW'(aux_q);
					l_wd = NONE_IDX;
				end
				state_d = S_DONE;
			end
			S_PMOD: begin
				case (func_q)
					FN_DIRTY: begin
						p_we    = 1'b1;
						p_wd.st = BS_DIRTY;
						cnt_en  = 1'b1;
						cnt_old = p_rd.st;
						cnt_new = BS_DIRTY;
					end
					FN_ERASE: begin
						p_we      = (p_rd.wear != ERASE_MAX);
						p_wd.wear = p_rd.wear + 1'b1;
					end
					default: begin
						res_d.owner = p_rd.owner;
						res_d.bst   = p_rd.st;
						res_d.ec    = p_rd.wear;
					end
				endcase
				state_d = S_DONE;
			end
			S_SCAN: begin
				p_ra  = cnt_q;
				cnt_d = cnt_q + 1'b1;
				if (CMP_W'(cnt_q) == eff_total - 1'b1) begin
					state_d = S_SCANEND;
				end
			end
			S_SCANEND: begin
				state_d = S_SCANFIN;
			end
			S_SCANFIN: begin
				if (best_q == NONE_IDX) begin
					res_d.rc = (func_q == FN_ALLOC) ? RC_NOFREE : RC_NONE;
				end else begin
					res_d.found = best_q;
					if (func_q == FN_ALLOC) begin
						p_we    = 1'b1;
						p_wa    = IW'(best_q);
						p_wd    = '{owner: bent_q.owner, st: BS_ACTIVE, wear: bent_q.wear};
						cnt_en  = 1'b1;
						cnt_old = BS_FREE;
						cnt_new = BS_ACTIVE;
					end else begin
						res_d.ec = bestc_q;
					end
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					out_load    = 1'b1;
					sweep_res_d = 1'b0;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase

		// a configuration write restarts the clearing pass
		if (cfg_we) begin
			state_d     = S_SWEEP;
			cnt_d       = '0;
			sweep_res_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			cnt_q       <= '0;
			sweep_res_q <= 1'b0;
			scan_vld_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			sweep_res_q <= sweep_res_d;
			scan_vld_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		func_q      <= func_d;
		lb_q        <= lb_d;
		pb_q        <= pb_d;
		aux_q       <= aux_d;
		res_q       <= res_d;
		scan_idx_s1 <= cnt_q;
	end

	// scan compare on the data returned for the previous address
	always_comb begin
		case (func_q)
			FN_ALLOC: scan_hit = (p_rd.st == BS_FREE) && (p_rd.wear < bestc_q);
			FN_MIN:   scan_hit = (p_rd.st != BS_BAD) && (p_rd.wear < bestc_q);
			default:  scan_hit = (p_rd.st != BS_BAD) && (p_rd.wear > bestc_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (scan_start) begin
			best_q  <= NONE_IDX;
			bestc_q <= (in_item.func == FN_MAX) ? '0 : ERASE_MAX;
		end else if (scan_vld_s1 && scan_hit) begin
			best_q  <= LW'(scan_idx_s1);
			bestc_q <= p_rd.wear;
			bent_q  <= p_rd;
		end
	end

	// running totals: leave old state, enter new state
	always_comb begin
		free_d  = free_q;
		dirty_d = dirty_q;
		bad_d   = bad_q;
		if (cnt_en) begin
			case (cnt_old)
				BS_FREE:  if (free_d != '0) free_d = free_d - 1'b1;
				BS_DIRTY: if (dirty_d != '0) dirty_d = dirty_d - 1'b1;
				BS_BAD:   if (bad_d != '0) bad_d = bad_d - 1'b1;
				default: ;
			endcase
			case (cnt_new)
				BS_FREE:  free_d = free_d + 1'b1;
				BS_DIRTY: dirty_d = dirty_d + 1'b1;
				BS_BAD:   bad_d = bad_d + 1'b1;
				default: ;
			endcase
		end
		if (sweep_end) begin
			free_d  = LW'(eff_total - eff_logical);
			dirty_d = '0;
			bad_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q  <= '0;
			dirty_q <= '0;
			bad_q   <= '0;
		end else begin
			free_q  <= free_d;
			dirty_q <= dirty_d;
			bad_q   <= bad_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.status         <= res_q.rc;
			out_q.found_physical <= 11'(res_q.found);
			out_q.owner_logical  <= 11'(res_q.owner);
			out_q.block_state    <= res_q.bst;
			out_q.wear_cnt       <= 32'(res_q.ec);
			out_q.free_cnt       <= 11'(free_q);
			out_q.dirty_cnt      <= 11'(dirty_q);
			out_q.bad_cnt        <= 11'(bad_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// totals never exceed the blocks in use outside the clearing pass
	a_totals: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_SWEEP) |-> ((CMP_W+2)'(free_q) + (CMP_W+2)'(dirty_q)
			+ (CMP_W+2)'(bad_q) <= (CMP_W+2)'(eff_total)))
		else $error("block totals exceed blocks in use");

	// a configuration write always restarts the clearing pass
	a_cfg_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (state_q == S_SWEEP) && (cnt_q == '0))
		else $error("config write did not restart clearing pass");

	// a new result is loaded only into a free output slot
	a_out_slot: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrote a pending result");

endmodule
